### rtl/core/sscs_pkg.sv
// ----------------------------------------------------------------------------
// sscs_pkg
// Shared codes, field widths and control types of the sparse-set store.
// ----------------------------------------------------------------------------
`default_nettype none

package sscs_pkg;

  localparam int CMD_W  = 3;
  localparam int ENT_W  = 10;
  localparam int POOL_W = 3;
  localparam int VAL_W  = 64;
  localparam int POS_W  = 8;
  localparam int STAT_W = 3;
  localparam int LIVE_W = 10;
  localparam int CFG_W  = 4;

  localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_ITERATE = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_POOL  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_ALIVE = 3'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT    = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STAT_W-1:0] ST_END       = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_CHECK,
    S_VERIFY,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic verify;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic more_pools;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/sscs_req_if.sv
// ----------------------------------------------------------------------------
// sscs_req_if
// Command channel: valid/ready with one command beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sscs_req_if;
  logic                         valid;
  logic                         ready;
  logic [sscs_pkg::CMD_W-1:0]   cmd;
  logic [sscs_pkg::ENT_W-1:0]   entity;
  logic [sscs_pkg::POOL_W-1:0]  pool;
  logic [sscs_pkg::VAL_W-1:0]   value;
  logic [sscs_pkg::POS_W-1:0]   position;

  modport source (output valid, cmd, entity, pool, value, position, input ready);
  modport sink (input valid, cmd, entity, pool, value, position, output ready);
endinterface

`default_nettype wire

### rtl/core/sscs_rsp_if.sv
// ----------------------------------------------------------------------------
// sscs_rsp_if
// Result channel: valid/ready with one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sscs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sscs_pkg::STAT_W-1:0]  status;
  logic [sscs_pkg::ENT_W-1:0]   entity_out;
  logic [sscs_pkg::VAL_W-1:0]   value_out;
  logic [sscs_pkg::LIVE_W-1:0]  live_entities;

  modport source (output valid, status, entity_out, value_out, live_entities, input ready);
  modport sink (input valid, status, entity_out, value_out, live_entities, output ready);
endinterface

`default_nettype wire

### rtl/core/sscs_ram.sv
// ----------------------------------------------------------------------------
// sscs_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sscs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/sscs_ctrl.sv
// ----------------------------------------------------------------------------
// sscs_ctrl
// Command sequencer: lookup, slot check, last-slot fetch, execute.
// ----------------------------------------------------------------------------
`default_nettype none

module sscs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire sscs_pkg::dp_stat_t stat,
  output sscs_pkg::dp_cmd_t       cmd
);

  sscs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sscs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      sscs_pkg::S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
        if (req_valid) begin
          state_next = sscs_pkg::S_CHECK;
        end
      end
      sscs_pkg::S_LOOK: begin
        state_next = sscs_pkg::S_CHECK;
      end
      sscs_pkg::S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = sscs_pkg::S_VERIFY;
      end
      sscs_pkg::S_VERIFY: begin
        cmd.verify = 1'b1;
        state_next = sscs_pkg::S_EXEC;
      end
      sscs_pkg::S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec   = 1'b1;
          state_next = stat.more_pools ? sscs_pkg::S_LOOK : sscs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sscs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/sscs_dp.sv
// ----------------------------------------------------------------------------
// sscs_dp
// Datapath: alive map, sparse and dense memories, fill counts, result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sscs_dp #(
  parameter int MAX_ENTITIES  = 1024,
  parameter int MAX_POOLS     = 8,
  parameter int POOL_CAPACITY = 256,
  parameter int DATA_WIDTH    = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire sscs_pkg::dp_cmd_t                 cmd,
  output sscs_pkg::dp_stat_t                     stat,
  input  wire logic [sscs_pkg::CMD_W-1:0]        in_cmd,
  input  wire logic [sscs_pkg::ENT_W-1:0]        in_entity,
  input  wire logic [sscs_pkg::POOL_W-1:0]       in_pool,
  input  wire logic [sscs_pkg::VAL_W-1:0]        in_value,
  input  wire logic [sscs_pkg::POS_W-1:0]        in_position,
  input  wire logic                              cfg_we,
  input  wire logic [sscs_pkg::CFG_W-1:0]        cfg_data,
  sscs_rsp_if.source                             rsp
);

  localparam int EW   = $clog2(MAX_ENTITIES);
  localparam int NW   = $clog2(MAX_ENTITIES + 1);
  localparam int PW   = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
  localparam int SW   = (POOL_CAPACITY > 1) ? $clog2(POOL_CAPACITY) : 1;
  localparam int FW   = $clog2(POOL_CAPACITY + 1);
  localparam int SDEP = MAX_POOLS * MAX_ENTITIES;
  localparam int DDEP = MAX_POOLS * POOL_CAPACITY;
  localparam int SAW  = (SDEP > 1) ? $clog2(SDEP) : 1;
  localparam int DAW  = (DDEP > 1) ? $clog2(DDEP) : 1;

  logic [sscs_pkg::CMD_W-1:0]  cmd_r;
  logic [sscs_pkg::ENT_W-1:0]  ent_r;
  logic [PW-1:0]               pool_r;
  logic                        pool_ok_r;
  logic [DATA_WIDTH-1:0]       val_r;
  logic [sscs_pkg::POS_W-1:0]  pos_r;
  logic [sscs_pkg::CFG_W-1:0]  cfg_r;
  logic [NW-1:0]               next_id;
  logic [sscs_pkg::LIVE_W-1:0] live;
  logic [FW-1:0]               fill [MAX_POOLS];
  logic                        alive_ok_r;
  logic [SW-1:0]               slot_r;
  logic [EW-1:0]               ent_s_r;
  logic [DATA_WIDTH-1:0]       data_s_r;

  logic                        out_valid;
  logic [sscs_pkg::STAT_W-1:0] out_status;
  logic [sscs_pkg::ENT_W-1:0]  out_ent;
  logic [DATA_WIDTH-1:0]       out_val;
  logic [sscs_pkg::LIVE_W-1:0] out_live;

  logic                        alive_rd;
  logic [SW-1:0]               sparse_rd;
  logic [EW-1:0]               dent_rd;
  logic [DATA_WIDTH-1:0]       data_rd;

  logic                        alive_we, alive_wdata;
  logic [EW-1:0]               alive_waddr, alive_raddr;
  logic                        sparse_we;
  logic [SAW-1:0]              sparse_waddr, sparse_raddr;
  logic [SW-1:0]               sparse_wdata;
  logic                        dent_we;
  logic [DAW-1:0]              dense_waddr, dense_raddr;
  logic [EW-1:0]               dent_wdata;
  logic                        data_we;
  logic [DATA_WIDTH-1:0]       data_wdata;

  logic [31:0]                 active;
  logic [31:0]                 cfg_active;
  logic [31:0]                 base;
  logic [sscs_pkg::POOL_W-1:0] load_pool;
  logic [FW-1:0]               fill_cur;
  logic [EW-1:0]               ent_idx;
  logic                        ent_ok;
  logic                        present;
  logic                        more;
  logic                        fill_inc, fill_dec, id_inc, live_inc, live_dec;
  logic [sscs_pkg::LIVE_W-1:0] live_next;
  logic [sscs_pkg::STAT_W-1:0] st_n;
  logic [sscs_pkg::ENT_W-1:0]  ent_n;
  logic [DATA_WIDTH-1:0]       val_n;

  assign active     = (32'(cfg_r) > MAX_POOLS) ? MAX_POOLS : 32'(cfg_r);
  assign cfg_active = (32'(cfg_data) > MAX_POOLS) ? MAX_POOLS : 32'(cfg_data);
  assign base       = 32'(pool_r) * POOL_CAPACITY;
  assign load_pool  = (in_cmd == sscs_pkg::CMD_DESTROY) ? '0 : in_pool;
  assign fill_cur   = fill[pool_r];
  assign ent_idx    = EW'(ent_r);
  assign ent_ok     = (ent_r != '0) && (32'(ent_r) < MAX_ENTITIES)
                      && (32'(ent_r) < 32'(next_id));
  assign present    = (32'(slot_r) < 32'(fill_cur)) && (ent_s_r == ent_idx);
  assign more       = (cmd_r == sscs_pkg::CMD_DESTROY) && alive_ok_r
                      && (32'(pool_r) + 32'd1 < active);

  assign stat.out_free   = !out_valid || rsp.ready;
  assign stat.more_pools = more;

  assign alive_raddr  = cmd.load ? EW'(in_entity) : ent_idx;
  assign sparse_raddr = cmd.load
                        ? SAW'(32'(load_pool) * MAX_ENTITIES + 32'(in_entity))
                        : SAW'(32'(pool_r) * MAX_ENTITIES + 32'(ent_r));

  always_comb begin
    if (cmd.check) begin
      if (cmd_r == sscs_pkg::CMD_ITERATE) begin
        dense_raddr = DAW'(base + 32'(pos_r));
      end else begin
        dense_raddr = DAW'(base + 32'(sparse_rd));
      end
    end else begin
      dense_raddr = DAW'(base + 32'(fill_cur) - 32'd1);
    end
  end

  sscs_ram #(.WIDTH(1), .DEPTH(MAX_ENTITIES)) u_alive (
    .clk(clk), .we(alive_we), .waddr(alive_waddr), .wdata(alive_wdata),
    .raddr(alive_raddr), .rdata(alive_rd)
  );

  sscs_ram #(.WIDTH(SW), .DEPTH(SDEP)) u_sparse (
    .clk(clk), .we(sparse_we), .waddr(sparse_waddr), .wdata(sparse_wdata),
    .raddr(sparse_raddr), .rdata(sparse_rd)
  );

  sscs_ram #(.WIDTH(EW), .DEPTH(DDEP)) u_dent (
    .clk(clk), .we(dent_we), .waddr(dense_waddr), .wdata(dent_wdata),
    .raddr(dense_raddr), .rdata(dent_rd)
  );

  sscs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DDEP)) u_data (
    .clk(clk), .we(data_we), .waddr(dense_waddr), .wdata(data_wdata),
    .raddr(dense_raddr), .rdata(data_rd)
  );

  always_comb begin
    alive_we     = 1'b0;
    alive_waddr  = ent_idx;
    alive_wdata  = 1'b0;
    sparse_we    = 1'b0;
    sparse_waddr = SAW'(32'(pool_r) * MAX_ENTITIES + 32'(ent_r));
    sparse_wdata = SW'(fill_cur);
    dent_we      = 1'b0;
    dent_wdata   = ent_idx;
    data_we      = 1'b0;
    data_wdata   = '0;
    dense_waddr  = DAW'(base + 32'(fill_cur));
    fill_inc     = 1'b0;
    fill_dec     = 1'b0;
    id_inc       = 1'b0;
    live_inc     = 1'b0;
    live_dec     = 1'b0;
    st_n         = sscs_pkg::ST_OK;
    ent_n        = '0;
    val_n        = '0;
    case (cmd_r)
      sscs_pkg::CMD_CREATE: begin
        if (32'(next_id) >= MAX_ENTITIES) begin
          st_n = sscs_pkg::ST_FULL;
        end else begin
          alive_we    = 1'b1;
          alive_waddr = EW'(next_id);
          alive_wdata = 1'b1;
          id_inc      = 1'b1;
          live_inc    = 1'b1;
          ent_n       = sscs_pkg::ENT_W'(next_id);
        end
      end
      sscs_pkg::CMD_DESTROY: begin
        if (!alive_ok_r) begin
          st_n = sscs_pkg::ST_NOT_ALIVE;
        end else begin
          if ((32'(pool_r) < active) && present) begin
            sparse_we    = 1'b1;
            sparse_waddr = SAW'(32'(pool_r) * MAX_ENTITIES + 32'(dent_rd));
            sparse_wdata = slot_r;
            dent_we      = 1'b1;
            dent_wdata   = dent_rd;
            data_we      = 1'b1;
            data_wdata   = data_rd;
            dense_waddr  = DAW'(base + 32'(slot_r));
            fill_dec     = 1'b1;
          end
          if (!more) begin
            alive_we = 1'b1;
            live_dec = 1'b1;
          end
        end
      end
      sscs_pkg::CMD_ADD, sscs_pkg::CMD_SET, sscs_pkg::CMD_GET, sscs_pkg::CMD_REMOVE: begin
        if (!pool_ok_r) begin
          st_n = sscs_pkg::ST_BAD_POOL;
        end else if (!alive_ok_r) begin
          st_n = sscs_pkg::ST_NOT_ALIVE;
        end else if (cmd_r == sscs_pkg::CMD_GET) begin
          if (present) begin
            val_n = data_s_r;
          end else begin
            st_n = sscs_pkg::ST_ABSENT;
          end
        end else if (cmd_r == sscs_pkg::CMD_REMOVE) begin
          if (present) begin
            sparse_we    = 1'b1;
            sparse_waddr = SAW'(32'(pool_r) * MAX_ENTITIES + 32'(dent_rd));
            sparse_wdata = slot_r;
            dent_we      = 1'b1;
            dent_wdata   = dent_rd;
            data_we      = 1'b1;
            data_wdata   = data_rd;
            dense_waddr  = DAW'(base + 32'(slot_r));
            fill_dec     = 1'b1;
          end else begin
            st_n = sscs_pkg::ST_ABSENT;
          end
        end else begin
          data_wdata = (cmd_r == sscs_pkg::CMD_SET) ? val_r : '0;
          if (present) begin
            data_we     = 1'b1;
            dense_waddr = DAW'(base + 32'(slot_r));
            val_n       = data_wdata;
          end else if (32'(fill_cur) >= POOL_CAPACITY) begin
            st_n = sscs_pkg::ST_FULL;
          end else begin
            sparse_we = 1'b1;
            dent_we   = 1'b1;
            data_we   = 1'b1;
            fill_inc  = 1'b1;
            val_n     = data_wdata;
          end
        end
      end
      sscs_pkg::CMD_ITERATE: begin
        if (!pool_ok_r) begin
          st_n = sscs_pkg::ST_BAD_POOL;
        end else if ((32'(pos_r) >= 32'(fill_cur)) || (32'(pos_r) >= POOL_CAPACITY)) begin
          st_n = sscs_pkg::ST_END;
        end else begin
          ent_n = sscs_pkg::ENT_W'(ent_s_r);
          val_n = data_s_r;
        end
      end
      default: begin
        st_n = sscs_pkg::ST_OK;
      end
    endcase
    if (!cmd.exec) begin
      alive_we  = 1'b0;
      sparse_we = 1'b0;
      dent_we   = 1'b0;
      data_we   = 1'b0;
      fill_inc  = 1'b0;
      fill_dec  = 1'b0;
      id_inc    = 1'b0;
      live_inc  = 1'b0;
      live_dec  = 1'b0;
    end
  end

  assign live_next = live + sscs_pkg::LIVE_W'(live_inc) - sscs_pkg::LIVE_W'(live_dec);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      next_id   <= NW'(1);
      live      <= '0;
      cfg_r     <= '0;
      for (int p = 0; p < MAX_POOLS; p++) begin
        fill[p] <= '0;
      end
    end else begin
      if (cmd.exec && !more) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (id_inc) begin
        next_id <= next_id + NW'(1);
      end
      live <= live_next;
      if (cfg_we) begin
        cfg_r <= cfg_data;
        for (int p = 0; p < MAX_POOLS; p++) begin
          if (p >= cfg_active) begin
            fill[p] <= '0;
          end
        end
      end else if (fill_inc) begin
        fill[pool_r] <= fill_cur + FW'(1);
      end else if (fill_dec) begin
        fill[pool_r] <= fill_cur - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_cmd;
      ent_r     <= in_entity;
      pool_r    <= PW'(load_pool);
      pool_ok_r <= 32'(in_pool) < active;
      val_r     <= in_value[DATA_WIDTH-1:0];
      pos_r     <= in_position;
    end else if (cmd.exec && more) begin
      pool_r <= pool_r + PW'(1);
    end
    if (cmd.check) begin
      alive_ok_r <= ent_ok && alive_rd;
      slot_r     <= sparse_rd;
    end
    if (cmd.verify) begin
      ent_s_r  <= dent_rd;
      data_s_r <= data_rd;
    end
    if (cmd.exec && !more) begin
      out_status <= st_n;
      out_ent    <= ent_n;
      out_val    <= val_n;
      out_live   <= live_next;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.entity_out    = out_ent;
  assign rsp.value_out     = sscs_pkg::VAL_W'(out_val);
  assign rsp.live_entities = out_live;

endmodule

`default_nettype wire

### rtl/core/sparse_set_component_store.sv
// ----------------------------------------------------------------------------
// sparse_set_component_store
// Entity allocator with sparse-set component pools and swap-remove.
//
// Channels: req carries one command beat (cmd, entity, pool, value,
// position), rsp returns one result beat per command (status, entity_out,
// value_out, live_entities). cfg_we/cfg_data write pools_in_use; write it
// only while no command is in flight.
// The key lookup read is issued at the accepting edge. The result is valid
// after slot check, last-slot fetch and execute, each bound by a registered
// memory read. A new command is taken only in the idle state, after the
// previous command has executed.
// Destroy repeats these steps, with a lookup, for each further pool in use.
// A new command is taken while the previous result waits in the output
// register; execute holds while that register is still full, so receiver
// stalls delay the next result.
// Reset clears the alive map by the identifier count, empties every pool
// and sets pools_in_use to 0; no memory sweep is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_set_component_store #(
  parameter int MAX_ENTITIES  = 1024,
  parameter int MAX_POOLS     = 8,
  parameter int POOL_CAPACITY = 256,
  parameter int DATA_WIDTH    = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  sscs_req_if.sink                        req,
  sscs_rsp_if.source                      rsp,
  input  wire logic                       cfg_we,
  input  wire logic [sscs_pkg::CFG_W-1:0] cfg_data
);

  sscs_pkg::dp_cmd_t  cmd;
  sscs_pkg::dp_stat_t stat;
  logic               ready;

  assign req.ready = ready;

  sscs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(ready),
    .stat(stat), .cmd(cmd)
  );

  sscs_dp #(
    .MAX_ENTITIES(MAX_ENTITIES), .MAX_POOLS(MAX_POOLS),
    .POOL_CAPACITY(POOL_CAPACITY), .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_cmd(req.cmd), .in_entity(req.entity), .in_pool(req.pool),
    .in_value(req.value), .in_position(req.position),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .rsp(rsp)
  );

endmodule

`default_nettype wire
